// ----- rtl/sle_pkg.sv -----
package sle_pkg;

  localparam int LINE_W  = 9;
  localparam int DOT_W   = 9;
  localparam int BYTE_W  = 8;
  localparam int EPTR_W  = 8;
  localparam int SPTR_W  = 5;
  localparam int SLOT_W  = 3;
  localparam int FIELD_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT_16  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RENDERING_ENABLED = 1'd1;

  // item kinds
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // evaluation flag bit positions
  localparam int FLAG_PRI_WRAP = 0;
  localparam int FLAG_SEC_WRAP = 1;
  localparam int FLAG_SEARCH   = 2;

  // sprite-zero flag bit positions
  localparam int S0_NEXT = 0;
  localparam int S0_CURR = 1;

  // scanline and dot landmarks
  localparam logic [LINE_W-1:0] LINE_VISIBLE_END = 9'd240;
  localparam logic [LINE_W-1:0] LINE_PRERENDER   = 9'd261;
  localparam logic [DOT_W-1:0]  DOT_CLEAR_END    = 9'd64;
  localparam logic [DOT_W-1:0]  DOT_SPRITE_ZERO  = 9'd65;
  localparam logic [DOT_W-1:0]  DOT_EVAL_END     = 9'd256;
  localparam logic [DOT_W-1:0]  DOT_LOAD_END     = 9'd320;
  localparam logic [DOT_W-1:0]  DOT_PRERENDER_S0 = 9'd1;

  localparam logic [BYTE_W-1:0] SEC_CLEAR_BYTE = 8'hFF;
  localparam logic [LINE_W-1:0] HEIGHT_8  = 9'd8;
  localparam logic [LINE_W-1:0] HEIGHT_16 = 9'd16;

endpackage

// ----- rtl/sprite_line_evaluator_unit.sv -----
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall  | func, line, dot, oam_index, oam_data
// out_    | output    | out_valid / out_stall| sprite_zero_on_line, overflow_raised,
//         |           |                      | load_valid, load_slot, load_field, load_byte
// cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A beat goes from the input register to the result register; one beat is taken
// every cycle while out_stall is low. The rate is set by the single evaluation
// stage between the input register and the result register, with the sprite
// memory read registered into mem_q_r, the memory read register, on even evaluation dots.
// Reset (rst_n low, synchronous) clears the pointers, flags and configuration;
// sprite memory contents are left as they are. A stalled result holds the
// evaluation stage, and in_stall rises once the input register is also full.
module sprite_line_evaluator_unit
  import sle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic [LINE_W-1:0]     in_line,
  input  logic [DOT_W-1:0]      in_dot,
  input  logic [EPTR_W-1:0]     in_oam_index,
  input  logic [BYTE_W-1:0]     in_oam_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_sprite_zero_on_line,
  output logic                  out_overflow_raised,
  output logic                  out_load_valid,
  output logic [SLOT_W-1:0]     out_load_slot,
  output logic [FIELD_W-1:0]    out_load_field,
  output logic [BYTE_W-1:0]     out_load_byte,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic cfg_h16_r;
  logic cfg_ren_r;

  // input register
  logic                 a_valid_r;
  logic                 a_func_r;
  logic [LINE_W-1:0]    a_line_r;
  logic [DOT_W-1:0]     a_dot_r;
  logic [EPTR_W-1:0]    a_idx_r;
  logic [BYTE_W-1:0]    a_data_r;

  // result register
  logic                 out_valid_r;
  logic                 out_s0_r;
  logic                 out_ovf_r;
  logic                 out_lv_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [FIELD_W-1:0]   out_field_r;
  logic [BYTE_W-1:0]    out_byte_r;

  // evaluation state
  logic [EPTR_W-1:0]    ep_r, ep_nxt;
  logic [SPTR_W-1:0]    sp_r, sp_nxt;
  logic [BYTE_W-1:0]    fb_r, fb_nxt;
  logic                 fb_mem_r, fb_mem_nxt;   // fetched byte lives in mem_q_r
  logic [1:0]           cr_r, cr_nxt;
  logic [2:0]           flags_r, flags_nxt;
  logic [1:0]           s0_r, s0_nxt;

  // memories
  logic [BYTE_W-1:0]    primary_mem [2**EPTR_W];
  logic [BYTE_W-1:0]    mem_q_r;
  logic [BYTE_W-1:0]    sec_mem [2**SPTR_W];

  // step control and results
  logic                 adv;
  logic                 do_step;
  logic                 prim_we;
  logic                 fetch;
  logic                 sec_we;
  logic [SPTR_W-1:0]    sec_waddr;
  logic [BYTE_W-1:0]    sec_wdata;
  logic [SPTR_W-1:0]    sec_raddr;
  logic [BYTE_W-1:0]    sec_rdata;
  logic                 ovf_nxt;
  logic                 lv_nxt;
  logic [SLOT_W-1:0]    slot_nxt;
  logic [FIELD_W-1:0]   field_nxt;
  logic [BYTE_W-1:0]    byte_nxt;

  // evaluation datapath
  logic [BYTE_W-1:0]    fb_cur;
  logic [LINE_W-1:0]    fb_ext;
  logic [LINE_W-1:0]    y_diff;
  logic [LINE_W-1:0]    height;
  logic                 y_hit;
  logic                 wrapped;
  logic                 active;
  logic [EPTR_W:0]      ep_p4;
  logic [1:0]           ep_p1_lo;
  logic [EPTR_W-1:0]    ep_inc;
  logic [SPTR_W-1:0]    sp_inc;

  // handshakes: the result stage advances when empty or when its beat is taken
  assign adv       = !out_valid_r || !out_stall;
  assign do_step   = a_valid_r && adv;
  assign in_stall  = a_valid_r && !adv;
  assign cfg_ready = 1'b1;

  assign out_valid               = out_valid_r;
  assign out_sprite_zero_on_line = out_s0_r;
  assign out_overflow_raised     = out_ovf_r;
  assign out_load_valid          = out_lv_r;
  assign out_load_slot           = out_slot_r;
  assign out_load_field          = out_field_r;
  assign out_load_byte           = out_byte_r;

  // the fetched byte comes from the memory read register until overwritten
  assign fb_cur   = fb_mem_r ? mem_q_r : fb_r;
  assign fb_ext   = {1'b0, fb_cur};
  assign y_diff   = a_line_r - fb_ext;
  assign height   = cfg_h16_r ? HEIGHT_16 : HEIGHT_8;
  assign y_hit    = (a_line_r >= fb_ext) && (y_diff < height);
  assign wrapped  = flags_r[FLAG_PRI_WRAP] || flags_r[FLAG_SEC_WRAP];
  assign active   = cfg_ren_r && (a_line_r < LINE_VISIBLE_END);
  assign ep_p4    = {1'b0, ep_r} + 9'd4;
  assign ep_p1_lo = ep_r[1:0] + 2'd1;
  assign ep_inc   = ep_r + 8'd1;
  assign sp_inc   = sp_r + 5'd1;
  assign sec_rdata = sec_mem[sec_raddr];
  assign prim_we  = do_step && (a_func_r == FUNC_WRITE);

  always_comb begin
    ep_nxt     = ep_r;
    sp_nxt     = sp_r;
    fb_nxt     = fb_r;
    fb_mem_nxt = fb_mem_r;
    cr_nxt     = cr_r;
    flags_nxt  = flags_r;
    s0_nxt     = s0_r;
    fetch      = 1'b0;
    sec_we     = 1'b0;
    sec_waddr  = sp_r;
    sec_wdata  = SEC_CLEAR_BYTE;
    sec_raddr  = sp_r;
    ovf_nxt    = 1'b0;
    lv_nxt     = 1'b0;
    slot_nxt   = '0;
    field_nxt  = '0;
    byte_nxt   = '0;

    if (a_func_r == FUNC_TICK) begin
      // pre-render line drops the next-line sprite-zero flag
      if (a_line_r == LINE_PRERENDER && a_dot_r == DOT_PRERENDER_S0) begin
        s0_nxt[S0_NEXT] = 1'b0;
      end
      if (active) begin
        if (a_dot_r == '0) begin
          sp_nxt    = '0;
          flags_nxt = '0;
          sec_we    = 1'b1;
          sec_waddr = '0;
        end else if (a_dot_r < DOT_CLEAR_END) begin
          sec_we    = 1'b1;
          sec_waddr = a_dot_r[SPTR_W:1];
        end else if (a_dot_r < DOT_EVAL_END) begin
          if (!a_dot_r[0]) begin
            // even dot: read primary byte into the memory read register
            fetch      = 1'b1;
            fb_mem_nxt = 1'b1;
          end else begin
            if (a_dot_r == DOT_SPRITE_ZERO) begin
              s0_nxt[S0_NEXT] = y_hit;
            end
            if (!wrapped) begin
              sec_we    = 1'b1;
              sec_wdata = fb_cur;
            end else begin
              fb_nxt     = sec_rdata;
              fb_mem_nxt = 1'b0;
            end
            if (cr_r != 2'd0 || (y_hit && !wrapped)) begin
              // copy a byte: advance both pointers
              cr_nxt = (cr_r != 2'd0) ? cr_r - 2'd1 : 2'd3;
              ep_nxt = ep_inc;
              sp_nxt = sp_inc;
              if (ep_inc == '0) begin
                flags_nxt[FLAG_PRI_WRAP] = 1'b1;
              end
              if (sp_inc == '0) begin
                flags_nxt[FLAG_SEC_WRAP] = 1'b1;
                flags_nxt[FLAG_SEARCH]   = 1'b1;
              end
            end else if (flags_r[FLAG_SEARCH]) begin
              if (y_hit && !flags_r[FLAG_PRI_WRAP]) begin
                ovf_nxt                = 1'b1;
                flags_nxt[FLAG_SEARCH] = 1'b0;
              end else begin
                // diagonal walk: next sprite and next byte within it
                ep_nxt = {ep_p4[EPTR_W-1:2], ep_p1_lo};
                if (ep_p4[EPTR_W]) begin
                  flags_nxt[FLAG_PRI_WRAP] = 1'b1;
                end
              end
            end else begin
              ep_nxt = {ep_p4[EPTR_W-1:2], 2'b00};
              if (ep_p4[EPTR_W]) begin
                flags_nxt[FLAG_PRI_WRAP] = 1'b1;
              end
            end
          end
        end else if (a_dot_r < DOT_LOAD_END) begin
          if (a_dot_r == DOT_EVAL_END) begin
            sec_raddr = '0;
          end
          if (!a_dot_r[2]) begin
            lv_nxt    = 1'b1;
            slot_nxt  = a_dot_r[5:3];
            field_nxt = a_dot_r[1:0];
            byte_nxt  = sec_rdata;
            sp_nxt    = sec_raddr + 5'd1;
          end else begin
            sp_nxt = sec_raddr;
          end
          if (a_dot_r != DOT_EVAL_END) begin
            s0_nxt[S0_CURR] = s0_nxt[S0_NEXT];
            ep_nxt          = '0;
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_h16_r   <= 1'b0;
      cfg_ren_r   <= 1'b0;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      ep_r        <= '0;
      sp_r        <= '0;
      fb_r        <= '0;
      fb_mem_r    <= 1'b0;
      cr_r        <= '0;
      flags_r     <= '0;
      s0_r        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SPRITE_HEIGHT_16:  cfg_h16_r <= cfg_data[0];
          CFG_RENDERING_ENABLED: cfg_ren_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        a_valid_r <= 1'b1;
      end else if (adv) begin
        a_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= a_valid_r;
      end
      if (do_step) begin
        ep_r     <= ep_nxt;
        sp_r     <= sp_nxt;
        fb_r     <= fb_nxt;
        fb_mem_r <= fb_mem_nxt;
        cr_r     <= cr_nxt;
        flags_r  <= flags_nxt;
        s0_r     <= s0_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_func_r <= in_func;
      a_line_r <= in_line;
      a_dot_r  <= in_dot;
      a_idx_r  <= in_oam_index;
      a_data_r <= in_oam_data;
    end
    if (do_step) begin
      out_s0_r    <= s0_nxt[S0_CURR];
      out_ovf_r   <= ovf_nxt;
      out_lv_r    <= lv_nxt;
      out_slot_r  <= slot_nxt;
      out_field_r <= field_nxt;
      out_byte_r  <= byte_nxt;
    end
  end

  // primary sprite memory: one write port, registered read on fetch dots
  always_ff @(posedge clk) begin
    if (prim_we) begin
      primary_mem[a_idx_r] <= a_data_r;
    end
    if (do_step && fetch) begin
      mem_q_r <= primary_mem[ep_r];
    end
  end

  // secondary store
  always_ff @(posedge clk) begin
    if (do_step && sec_we) begin
      sec_mem[sec_waddr] <= sec_wdata;
    end
  end

endmodule
